>>> src/gra_pkg.sv
// ----------------------------------------------------------------------------
// gra_pkg: shared types and constants for the greedy row assignment block
// Field widths, cost limits, register map and default sizing.
// ----------------------------------------------------------------------------
package gra_pkg;

  // Payload field widths.
  localparam int COST_W  = 30;
  localparam int TOTAL_W = 36;
  localparam int IDX_W   = 7;
  localparam int SIZE_W  = 7;

  // Cost sentinel and the largest cost a result may carry.
  localparam logic [COST_W-1:0] COST_SENTINEL = 30'd1000000000;
  localparam logic [COST_W-1:0] COST_LIMIT    = 30'd999999999;

  // Sizing defaults.
  localparam int DEF_MAX_N = 64;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

  // Register port geometry.
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // Register indexes, taken from the word address bits.
  typedef enum logic [ADDR_W-3:0] {
    REG_MATRIX_SIZE = 1'b0
  } reg_idx_t;

endpackage

>>> src/gra_ifs.sv
// ----------------------------------------------------------------------------
// gra_ifs: valid/ready channel interfaces of the greedy row assignment block
// One interface for the cost stream and one for the assignment results.
// ----------------------------------------------------------------------------

// Cost stream, one matrix entry per transfer.
interface gra_in_if import gra_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [COST_W-1:0] cost;

  modport source (output valid, output cost, input ready);
  modport sink   (input valid, input cost, output ready);
endinterface

// Assignment results, one per matrix row.
interface gra_out_if import gra_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [IDX_W-1:0]   worker;
  logic [IDX_W-1:0]   assigned_job;
  logic [COST_W-1:0]  job_cost;
  logic [TOTAL_W-1:0] total_cost;
  logic               last_worker;

  modport source (output valid, output worker, output assigned_job, output job_cost,
                  output total_cost, output last_worker, input ready);
  modport sink   (input valid, input worker, input assigned_job, input job_cost,
                  input total_cost, input last_worker, output ready);
endinterface

>>> src/greedy_row_assignment.sv
// ----------------------------------------------------------------------------
// greedy_row_assignment: greedy worker-to-job assignment over a cost stream
// Streams an N-by-N cost matrix in row-major order and assigns each row the
// cheapest job not yet taken, reporting one result per row.
// ----------------------------------------------------------------------------
// Unless input is refused, the block takes one cost per clock cycle, back
// to back, with no gaps between rows or matrices. Each entry reads the
// job-taken memory in the cycle it is accepted and is compared against
// the running row minimum in the next cycle; a row's result passes from
// that compare stage into the output register. A job marked taken at the
// end of one row is forwarded to the read that happens in the same cycle.
// Results are held in an output register; input is refused only while a
// row result is ready to leave and the previous one is still waiting.
// Writing matrix_size abandons any matrix in progress. No clearing pass is
// needed after reset or between matrices.
module greedy_row_assignment import gra_pkg::*; #(
  parameter int MAX_N = DEF_MAX_N
) (
  input  logic              clk,
  input  logic              rst_n,
  gra_in_if.sink            in_ch,
  gra_out_if.source         out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int CW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(MAX_N);

  // Configuration and counters.
  logic [SIZE_W-1:0]  size_r;
  logic [SIZE_W-1:0]  n_eff;
  logic [CW-1:0]      col_r;
  logic [CW-1:0]      row_r;

  // Job-taken memory and its per-matrix valid bits.
  logic               taken_mem [MAX_N];
  logic [MAX_N-1:0]   valid_r;
  logic               rd_q_r;
  logic               fwd_r;
  logic               wr_en;
  logic [CW-1:0]      wr_addr;

  // Compare stage.
  logic               s1_v_r;
  logic [COST_W-1:0]  s1_cost_r;
  logic [CW-1:0]      s1_col_r;
  logic               s1_end;
  logic               s1_go;
  logic               stall1;
  logic               taken1;
  logic               better;
  logic [COST_W-1:0]  cand_cost;
  logic [CW-1:0]      cand_col;
  logic [COST_W-1:0]  fin_cost;
  logic [TOTAL_W-1:0] total_nxt;
  logic               last_row;

  // Row tracking.
  logic [COST_W-1:0]  best_cost_r;
  logic [CW-1:0]      best_col_r;
  logic [TOTAL_W-1:0] total_r;

  // Output register.
  logic               out_valid_r;
  logic [IDX_W-1:0]   out_worker_r;
  logic [IDX_W-1:0]   out_job_r;
  logic [COST_W-1:0]  out_cost_r;
  logic [TOTAL_W-1:0] out_total_r;
  logic               out_last_r;

  logic               in_acc;
  logic               cfg_wr;
  logic [COST_W-1:0]  in_cost_sat;
  reg_idx_t           reg_idx;

  // Register port decode.
  assign reg_idx    = reg_idx_t'(cfg_paddr[ADDR_W-1:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && (reg_idx == REG_MATRIX_SIZE);
  assign cfg_pready = 1'b1;

  always_comb begin
    case (reg_idx)
      REG_MATRIX_SIZE: cfg_prdata = DATA_W'(size_r);
      default:         cfg_prdata = '0;
    endcase
  end

  // Effective matrix size, clamped to the supported range.
  always_comb begin
    if (size_r == '0) begin
      n_eff = SIZE_W'(1);
    end else if (size_r > MAX_SIZE) begin
      n_eff = MAX_SIZE;
    end else begin
      n_eff = size_r;
    end
  end

  // Input handshake and cost saturation.
  assign stall1      = s1_v_r && s1_end && out_valid_r && !out_ch.ready;
  assign in_ch.ready = !stall1;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_cost_sat = (in_ch.cost > COST_LIMIT) ? COST_LIMIT : in_ch.cost;

  // Compare stage: taken lookup, running minimum and row end.
  assign s1_go     = s1_v_r && !stall1;
  assign s1_end    = (SIZE_W'(s1_col_r) == n_eff - SIZE_W'(1));
  assign taken1    = (rd_q_r && valid_r[s1_col_r]) || fwd_r;
  assign better    = !taken1 && (s1_cost_r < best_cost_r);
  assign cand_cost = better ? s1_cost_r : best_cost_r;
  assign cand_col  = better ? s1_col_r : best_col_r;
  assign fin_cost  = (cand_cost >= COST_SENTINEL) ? COST_LIMIT : cand_cost;
  assign total_nxt = total_r + TOTAL_W'(fin_cost);
  assign last_row  = ((SIZE_W'(row_r) + SIZE_W'(1)) >= n_eff);

  // A row that is not the last marks its chosen job taken.
  assign wr_en   = s1_go && s1_end && !last_row;
  assign wr_addr = cand_col;

  // Taken memory: read on acceptance, written at the end of a row.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      taken_mem[wr_addr] <= 1'b1;
    end
    if (in_acc) begin
      rd_q_r <= taken_mem[col_r];
    end
  end

  // Stage payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cost_r <= in_cost_sat;
      s1_col_r  <= col_r;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r      <= SIZE_RESET;
      col_r       <= '0;
      row_r       <= '0;
      valid_r     <= '0;
      fwd_r       <= 1'b0;
      s1_v_r      <= 1'b0;
      best_cost_r <= COST_SENTINEL;
      best_col_r  <= '0;
      total_r     <= '0;
    end else if (cfg_wr) begin
      size_r      <= cfg_pwdata[SIZE_W-1:0];
      col_r       <= '0;
      row_r       <= '0;
      valid_r     <= '0;
      fwd_r       <= 1'b0;
      s1_v_r      <= 1'b0;
      best_cost_r <= COST_SENTINEL;
      best_col_r  <= '0;
      total_r     <= '0;
    end else begin
      // Column counter and forwarding of a same-cycle write.
      if (in_acc) begin
        if (SIZE_W'(col_r) == n_eff - SIZE_W'(1)) begin
          col_r <= '0;
        end else begin
          col_r <= col_r + CW'(1);
        end
        fwd_r  <= wr_en && (wr_addr == col_r);
        s1_v_r <= 1'b1;
      end else if (s1_go) begin
        s1_v_r <= 1'b0;
      end

      // Running minimum and end-of-row bookkeeping.
      if (s1_go) begin
        if (s1_end) begin
          best_cost_r <= COST_SENTINEL;
          best_col_r  <= '0;
          if (last_row) begin
            row_r   <= '0;
            total_r <= '0;
            valid_r <= '0;
          end else begin
            row_r            <= row_r + CW'(1);
            total_r          <= total_nxt;
            valid_r[wr_addr] <= 1'b1;
          end
        end else begin
          best_cost_r <= cand_cost;
          best_col_r  <= cand_col;
        end
      end
    end
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_end) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (s1_go && s1_end) begin
      out_worker_r <= IDX_W'(row_r) + IDX_W'(1);
      out_job_r    <= IDX_W'(cand_col) + IDX_W'(1);
      out_cost_r   <= fin_cost;
      out_total_r  <= total_nxt;
      out_last_r   <= last_row;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.worker       = out_worker_r;
  assign out_ch.assigned_job = out_job_r;
  assign out_ch.job_cost     = out_cost_r;
  assign out_ch.total_cost   = out_total_r;
  assign out_ch.last_worker  = out_last_r;

  // The number of taken jobs always equals the number of finished rows.
  a_taken_count : assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(row_r))
    else $error("taken map count differs from row count");

  // A job is never marked taken twice within one matrix.
  a_no_double_take : assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !valid_r[wr_addr])
    else $error("job assigned twice in one matrix");

  // The column counter stays inside the active matrix.
  a_col_range : assert property (@(posedge clk) disable iff (!rst_n)
    SIZE_W'(col_r) < n_eff)
    else $error("column counter out of range");

  // A row result always carries a real, saturated cost.
  a_cost_bound : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_cost_r <= COST_LIMIT))
    else $error("result cost above limit");

  // After the final row leaves the compare stage the taken map and total are clear.
  a_clear_after_last : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_end && last_row && !cfg_wr) |=> (valid_r == '0) && (total_r == '0))
    else $error("matrix state not cleared after last row");

endmodule

>>> sim/greedy_row_assignment_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// greedy_row_assignment_tb: self-checking bench for the greedy row assignment
// Streams cost matrices through the block, predicts each row's assignment in
// step with accepted transfers, and compares every result field by field.
// Directed tests cover the size extremes, tie breaking, cost saturation and
// abandoned matrices; random phases vary the size and the channel idling.
// ----------------------------------------------------------------------------
module greedy_row_assignment_tb import gra_pkg::*; ();

  // Number of cycles the block may still be busy after the last result.
  localparam int SETTLE_CYCLES = 4;

  // Size of the matrix that is streamed completely with near-limit costs.
  localparam int FULL_TEST_N = 16;

  // One row assignment as it leaves the block.
  typedef struct packed {
    logic [IDX_W-1:0]   worker;
    logic [IDX_W-1:0]   assigned_job;
    logic [COST_W-1:0]  job_cost;
    logic [TOTAL_W-1:0] total_cost;
    logic               last_worker;
  } assignment_t;

  // How the costs of a matrix are drawn.
  typedef enum logic [1:0] {
    STYLE_TIES,
    STYLE_NARROW,
    STYLE_FULL,
    STYLE_RAW
  } cost_style_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [ADDR_W-1:0] cfg_paddr;
  logic [DATA_W-1:0] cfg_pwdata;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  gra_in_if  in_ch ();
  gra_out_if out_ch ();

  greedy_row_assignment dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Predicted assignments still waiting to leave the block.
  assignment_t expected_assignments[$];

  // Shadow of the block's state.
  logic [SIZE_W-1:0]    size_reg;
  logic [DEF_MAX_N-1:0] job_busy;
  int unsigned          row_idx;
  int unsigned          col_idx;
  logic [COST_W-1:0]    row_best_cost;
  int unsigned          row_best_col;
  logic [TOTAL_W-1:0]   matrix_total;

  int unsigned items_sent;
  int unsigned mismatch_count;
  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Result receiver: stalls at random with the current stall rate.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Hard limit on the run time.
  initial begin
    #2ms;
    $display("Regression FAIL");
    $finish;
  end

  // Back to the state of a fresh matrix.
  function automatic void clear_matrix_state();
    job_busy      = '0;
    row_idx       = 0;
    col_idx       = 0;
    row_best_cost = COST_SENTINEL;
    row_best_col  = 0;
    matrix_total  = '0;
  endfunction

  // Advance the shadow state by one accepted cost; queue the row result if any.
  function automatic void predict_assignment(input logic [COST_W-1:0] cost_in);
    int unsigned       n;
    int unsigned       col;
    logic [COST_W-1:0] c;
    assignment_t       res;
    n   = (size_reg == 0) ? 1 : (size_reg > DEF_MAX_N) ? DEF_MAX_N : size_reg;
    col = (col_idx >= n) ? n - 1 : col_idx;
    c   = (cost_in > COST_LIMIT) ? COST_LIMIT : cost_in;
    if (!job_busy[col] && c < row_best_cost) begin
      row_best_cost = c;
      row_best_col  = col;
    end
    if (col + 1 < n) begin
      col_idx = col + 1;
      return;
    end
    if (row_best_cost >= COST_SENTINEL) begin
      row_best_cost = COST_LIMIT;
    end
    matrix_total     = matrix_total + TOTAL_W'(row_best_cost);
    res.worker       = IDX_W'(row_idx + 1);
    res.assigned_job = IDX_W'(row_best_col + 1);
    res.job_cost     = row_best_cost;
    res.total_cost   = matrix_total;
    res.last_worker  = (row_idx + 1 >= n);
    expected_assignments.push_back(res);
    if (res.last_worker) begin
      clear_matrix_state();
    end else begin
      job_busy[row_best_col] = 1'b1;
      row_idx       = row_idx + 1;
      col_idx       = 0;
      row_best_cost = COST_SENTINEL;
      row_best_col  = 0;
    end
  endfunction

  function automatic void check_field(input string name, input logic [TOTAL_W-1:0] want,
                                      input logic [TOTAL_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Compare each result transfer with the oldest prediction.
  always @(posedge clk) begin
    assignment_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_assignments.size() == 0) begin
        $error("unexpected result: worker %0d job %0d", out_ch.worker, out_ch.assigned_job);
        mismatch_count++;
      end else begin
        want = expected_assignments.pop_front();
        check_field("worker", want.worker, out_ch.worker);
        check_field("assigned_job", want.assigned_job, out_ch.assigned_job);
        check_field("job_cost", want.job_cost, out_ch.job_cost);
        check_field("total_cost", want.total_cost, out_ch.total_cost);
        check_field("last_worker", want.last_worker, out_ch.last_worker);
      end
    end
  end

  function automatic logic [COST_W-1:0] draw_cost(input cost_style_t style);
    logic [COST_W-1:0] c;
    case (style)
      STYLE_TIES:   c = COST_W'($urandom_range(3));
      STYLE_NARROW: c = COST_W'($urandom_range(999));
      STYLE_FULL:   c = COST_W'($urandom_range(COST_LIMIT));
      default:      c = COST_W'($urandom());
    endcase
    // Now and then a cost at or above the sentinel.
    if ($urandom_range(19) == 0) begin
      c = COST_W'($urandom_range(32'h3FFF_FFFF, COST_SENTINEL));
    end
    return c;
  endfunction

  // Offer one cost, with random idle cycles ahead of it, and wait for the transfer.
  task automatic send_cost(input logic [COST_W-1:0] c);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cost  <= c;
    do @(posedge clk); while (!in_ch.ready);
    predict_assignment(c);
    items_sent++;
  endtask

  task automatic send_random_costs(input int unsigned count, input cost_style_t style);
    repeat (count) send_cost(draw_cost(style));
  endtask

  // Stop sending and wait until every predicted result has left the block.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (expected_assignments.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write, after draining all results: setup cycle, then access cycle until pready.
  task automatic cfg_write(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    drain_results();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (idx == REG_MATRIX_SIZE) begin
      size_reg = value[SIZE_W-1:0];
      clear_matrix_state();
    end
  endtask

  // Register read, checked against the value last written.
  task automatic cfg_check_size();
    logic [DATA_W-1:0] data;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {REG_MATRIX_SIZE, 2'b00};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    data = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (data[SIZE_W-1:0] !== size_reg) begin
      $error("matrix_size: expected %0d, actual %0d", size_reg, data[SIZE_W-1:0]);
      mismatch_count++;
    end
  endtask

  // Reset size of 64: two rows, the first with a tie, the second forced onto job 64.
  task automatic test_default_size();
    cfg_check_size();
    for (int i = 0; i < DEF_MAX_N; i++) begin
      send_cost((i == 40 || i == 63) ? 30'd3 : 30'd500);
    end
    for (int i = 0; i < DEF_MAX_N; i++) begin
      send_cost((i == 40) ? 30'd0 : (i == 63) ? 30'd1 : COST_LIMIT);
    end
  endtask

  // Size one: every cost is a whole matrix, including both cost extremes.
  task automatic test_single_job();
    cfg_write(REG_MATRIX_SIZE, 1);
    send_cost(30'd0);
    send_cost(COST_LIMIT);
    send_cost(30'h3FFF_FFFF);
  endtask

  // Ties go to the lowest free column; costs at the sentinel saturate.
  task automatic test_ties_and_saturation();
    cfg_write(REG_MATRIX_SIZE, 3);
    repeat (6) send_cost(30'd5);
    send_cost(30'd7);
    send_cost(30'd0);
    send_cost(30'd7);
    cfg_write(REG_MATRIX_SIZE, 2);
    send_cost(30'h3FFF_FFFF);
    send_cost(COST_SENTINEL);
    send_cost(COST_SENTINEL + 30'd5);
    send_cost(30'd0);
  endtask

  // Sizes out of range clamp to 1 and to 64; a write abandons a partial row.
  task automatic test_size_clamp();
    cfg_write(REG_MATRIX_SIZE, 0);
    cfg_check_size();
    send_cost(30'd9);
    send_cost(30'd4);
    cfg_write(REG_MATRIX_SIZE, 127);
    cfg_check_size();
    send_random_costs(DEF_MAX_N + 6, STYLE_NARROW);
    cfg_write(REG_MATRIX_SIZE, 65);
    send_random_costs(3, STYLE_FULL);
  endtask

  // Rewriting the same size mid-matrix restarts rows, taken jobs and total.
  task automatic test_abandon_matrix();
    cfg_write(REG_MATRIX_SIZE, 3);
    send_cost(30'd2);
    send_cost(30'd1);
    send_cost(30'd8);
    send_cost(30'd0);
    cfg_write(REG_MATRIX_SIZE, 3);
    send_random_costs(9, STYLE_TIES);
  endtask

  // One complete matrix of near-limit and saturating costs, every row at the top.
  task automatic test_full_size_matrix();
    cfg_write(REG_MATRIX_SIZE, FULL_TEST_N);
    repeat (FULL_TEST_N * FULL_TEST_N) begin
      send_cost(COST_W'($urandom_range(32'h3FFF_FFFF, COST_LIMIT - 9)));
    end
  endtask

  // Random matrices of random sizes, with partial matrices and odd sizes mixed in.
  task automatic test_random_matrices(input int unsigned idle_pct, input int unsigned stall_pct,
                                      input int unsigned item_goal);
    int unsigned start;
    int unsigned n_raw;
    int unsigned n_eff;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    start = items_sent;
    while (items_sent - start < item_goal) begin
      case ($urandom_range(19))
        0:          n_raw = $urandom_range(127, 17);
        1:          n_raw = 0;
        2, 3, 4, 5: n_raw = $urandom_range(16, 7);
        default:    n_raw = $urandom_range(6, 1);
      endcase
      n_eff = (n_raw == 0) ? 1 : (n_raw > DEF_MAX_N) ? DEF_MAX_N : n_raw;
      cfg_write(REG_MATRIX_SIZE, n_raw);
      if (n_eff > 16) begin
        // Large sizes: one or two rows and possibly part of a third, abandoned by the next write.
        send_random_costs(n_eff * $urandom_range(2, 1) + $urandom_range(n_eff - 1),
                          cost_style_t'($urandom_range(3)));
      end else begin
        repeat ($urandom_range(3, 1)) begin
          send_random_costs(n_eff * n_eff, cost_style_t'($urandom_range(3)));
          // The sender sometimes waits for every result before going on.
          if ($urandom_range(7) == 0) begin
            drain_results();
          end
        end
        if (n_eff > 1 && $urandom_range(3) == 0) begin
          send_random_costs($urandom_range(n_eff * n_eff - 1, 1),
                            cost_style_t'($urandom_range(3)));
        end
      end
    end
  endtask

  // Main sequence.
  initial begin
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.cost  <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    items_sent         = 0;
    mismatch_count     = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    size_reg = SIZE_RESET;
    clear_matrix_state();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_size();
    test_single_job();
    test_ties_and_saturation();
    test_size_clamp();
    test_abandon_matrix();
    test_full_size_matrix();
    test_random_matrices(0, 0, 300);
    test_random_matrices(55, 0, 300);
    test_random_matrices(0, 55, 300);
    test_random_matrices(25, 25, 300);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_assignments.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
src/gra_pkg.sv
src/gra_ifs.sv
src/greedy_row_assignment.sv
sim/greedy_row_assignment_tb.sv
